[sv/msva_pkg.sv]
package msva_pkg;

   localparam int COORD_WIDTH  = 16;
   // cross product term: difference of two coordinate products
   localparam int K_WIDTH      = 2 * COORD_WIDTH + 1;
   localparam int PROD_WIDTH   = COORD_WIDTH + K_WIDTH;
   // sum of three dot product terms, with headroom
   localparam int TRI_WIDTH    = PROD_WIDTH + 2;
   localparam int SUM_WIDTH    = 64;
   localparam int VOLUME_WIDTH = 61;
   localparam int VolDivisor   = 6;
   localparam int REM_WIDTH    = 3;
   // divide by six in 16-bit digits, most significant first
   localparam int DIV_CHUNK    = 16;
   localparam int DIV_STEPS    = SUM_WIDTH / DIV_CHUNK;
   localparam int CNT_WIDTH    = $clog2(DIV_STEPS);
   localparam int DIV_X_WIDTH  = REM_WIDTH + DIV_CHUNK;
   localparam int DIV_SHIFT    = 21;
   localparam int DIV_RECIP    = (2 ** DIV_SHIFT + VolDivisor - 1) / VolDivisor;
   localparam int RECIP_WIDTH  = $clog2(DIV_RECIP + 1);
   localparam int STEP_WIDTH   = 4;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] ax_coord;
      logic signed [COORD_WIDTH-1:0] ay_coord;
      logic signed [COORD_WIDTH-1:0] az_coord;
      logic signed [COORD_WIDTH-1:0] bx_coord;
      logic signed [COORD_WIDTH-1:0] by_coord;
      logic signed [COORD_WIDTH-1:0] bz_coord;
      logic signed [COORD_WIDTH-1:0] cx_coord;
      logic signed [COORD_WIDTH-1:0] cy_coord;
      logic signed [COORD_WIDTH-1:0] cz_coord;
      logic                          last_triangle;
   } req_beat_type;

   typedef struct packed {
      logic [VOLUME_WIDTH-1:0] volume;
      logic                    saturated;
   } rsp_beat_type;

endpackage

[sv/msva_req_if.sv]
interface msva_req_if;
   import msva_pkg::*;

   logic         valid;
   logic         ready;
   req_beat_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[sv/msva_rsp_if.sv]
interface msva_rsp_if;
   import msva_pkg::*;

   logic         valid;
   logic         ready;
   rsp_beat_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[sv/msva_mul.sv]
module msva_mul (
   input  logic                                   clock,
   input  logic signed [msva_pkg::COORD_WIDTH-1:0] a_op,
   input  logic signed [msva_pkg::K_WIDTH-1:0]     b_op,
   output logic signed [msva_pkg::PROD_WIDTH-1:0]  product_ff
);
   import msva_pkg::*;

   logic signed [PROD_WIDTH-1:0] product_in;

   always_comb begin
      product_in = PROD_WIDTH'(a_op) * PROD_WIDTH'(b_op);
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end
endmodule

[sv/msva_div6.sv]
module msva_div6 (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [msva_pkg::SUM_WIDTH-1:0]        dividend,
   output logic                                  done_ff,
   output logic [msva_pkg::VOLUME_WIDTH-1:0]     quotient
);
   import msva_pkg::*;

   localparam logic [CNT_WIDTH-1:0]   CNT_LAST = CNT_WIDTH'(DIV_STEPS - 1);
   localparam logic [RECIP_WIDTH-1:0] RECIP    = RECIP_WIDTH'(DIV_RECIP);
   localparam logic [DIV_X_WIDTH-1:0] DIVISOR  = DIV_X_WIDTH'(VolDivisor);

   logic                                busy_ff, busy_in;
   logic                                done_in;
   logic [CNT_WIDTH-1:0]                cnt_ff, cnt_in;
   logic [SUM_WIDTH-1:0]                quo_ff, quo_in;
   logic [REM_WIDTH-1:0]                rem_ff, rem_in;
   logic [DIV_X_WIDTH-1:0]              part_x;
   logic [DIV_X_WIDTH+RECIP_WIDTH-1:0]  scaled;
   logic [DIV_CHUNK-1:0]                digit;
   logic [DIV_X_WIDTH-1:0]              back;

   // long division by six, one 16-bit digit per cycle; dividend digits shift
   // out of the top while quotient digits shift in at the bottom. The digit
   // comes from a reciprocal multiply, exact while part_x stays below 2^19.
   always_comb begin
      part_x  = {rem_ff, quo_ff[SUM_WIDTH-1 -: DIV_CHUNK]};
      scaled  = part_x * RECIP;
      digit   = scaled[DIV_SHIFT +: DIV_CHUNK];
      back    = part_x - DIVISOR * {{REM_WIDTH{1'b0}}, digit};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUM_WIDTH-DIV_CHUNK-1:0], digit};
         rem_in = back[REM_WIDTH-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient = quo_ff[VOLUME_WIDTH-1:0];

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff)) else $error("done without a run");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == CNT_LAST) |=> done_ff) else $error("missed done");
endmodule

[sv/mesh_signed_volume_accumulator_core.sv]
// Signed mesh volume accumulator.
// req_chan carries one triangle per beat: nine signed coordinates with
// 8 fraction bits and a last_triangle mark. Each triangle's triple product
// a.(b x c) is added to a 64-bit saturating sum. A beat with last_triangle
// set ends the mesh: rsp_chan then carries one beat with |sum|/6 (24
// fraction bits, truncated) and a flag that the sum clipped during the mesh;
// the sum and flag are then cleared. Other beats give no response.
// Each triangle passes through ST_MULT and ST_ACCUM before the next beat is
// taken: one shared 16 x 33 multiplier forms the nine products in turn,
// one per cycle, then ST_ACCUM adds the triple product to the sum. A last
// triangle adds the divide-by-six unit, one 16-bit quotient digit per cycle,
// before ST_EMIT loads the response register; the next beat is taken only
// after that.
// The response sits in an output register: a stalled receiver does not
// stop new triangles from being taken, only a second finished result waits
// until the first is taken.
// Synchronous reset clears the sum, the flag and all handshake state.
module mesh_signed_volume_accumulator_core (
   input logic         clock,
   input logic         reset,
   msva_req_if.sink    req_chan,
   msva_rsp_if.source  rsp_chan
);
   import msva_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_ACCUM,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   localparam logic [STEP_WIDTH-1:0] STEP_BYCZ = STEP_WIDTH'(0);
   localparam logic [STEP_WIDTH-1:0] STEP_BZCY = STEP_WIDTH'(1);
   localparam logic [STEP_WIDTH-1:0] STEP_BZCX = STEP_WIDTH'(2);
   localparam logic [STEP_WIDTH-1:0] STEP_BXCZ = STEP_WIDTH'(3);
   localparam logic [STEP_WIDTH-1:0] STEP_BXCY = STEP_WIDTH'(4);
   localparam logic [STEP_WIDTH-1:0] STEP_BYCX = STEP_WIDTH'(5);
   localparam logic [STEP_WIDTH-1:0] STEP_AXKX = STEP_WIDTH'(6);
   localparam logic [STEP_WIDTH-1:0] STEP_AYKY = STEP_WIDTH'(7);
   localparam logic [STEP_WIDTH-1:0] STEP_AZKZ = STEP_WIDTH'(8);
   localparam logic [STEP_WIDTH-1:0] STEP_DRAIN = STEP_WIDTH'(9);

   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   function automatic logic signed [K_WIDTH-1:0] widen_coord(
      input logic signed [COORD_WIDTH-1:0] c);
      widen_coord = {{(K_WIDTH-COORD_WIDTH){c[COORD_WIDTH-1]}}, c};
   endfunction

   state_type                     state_ff, state_in;
   logic [STEP_WIDTH-1:0]         step_ff, step_in;
   logic [STEP_WIDTH-1:0]         prev_step;
   req_beat_type                  beat_ff, beat_in;
   logic signed [K_WIDTH-1:0]     part_ff, part_in;
   logic signed [K_WIDTH-1:0]     kx_ff, kx_in, ky_ff, ky_in, kz_ff, kz_in;
   logic signed [TRI_WIDTH-1:0]   tri_ff, tri_in;
   logic signed [SUM_WIDTH-1:0]   sum_ff, sum_in;
   logic                          seen_ff, seen_in;
   logic                          sat_pend_ff, sat_pend_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_beat_type                  rsp_beat_ff, rsp_beat_in;

   logic signed [COORD_WIDTH-1:0] mul_a;
   logic signed [K_WIDTH-1:0]     mul_b;
   logic signed [PROD_WIDTH-1:0]  product;
   logic signed [K_WIDTH-1:0]     prod_k;
   logic signed [TRI_WIDTH-1:0]   prod_t;
   logic signed [SUM_WIDTH:0]     sum_wide;
   logic                          clip;
   logic signed [SUM_WIDTH-1:0]   sum_next;
   logic [SUM_WIDTH-1:0]          magnitude;
   logic                          div_start;
   logic                          div_done;
   logic [VOLUME_WIDTH-1:0]       div_quotient;
   logic                          take_req;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign take_req       = req_chan.valid && req_chan.ready;
   assign prev_step      = step_ff - 1'b1;

   // operand select for the shared multiplier
   always_comb begin
      case (step_ff)
         STEP_BYCZ: begin mul_a = beat_ff.by_coord; mul_b = widen_coord(beat_ff.cz_coord); end
         STEP_BZCY: begin mul_a = beat_ff.bz_coord; mul_b = widen_coord(beat_ff.cy_coord); end
         STEP_BZCX: begin mul_a = beat_ff.bz_coord; mul_b = widen_coord(beat_ff.cx_coord); end
         STEP_BXCZ: begin mul_a = beat_ff.bx_coord; mul_b = widen_coord(beat_ff.cz_coord); end
         STEP_BXCY: begin mul_a = beat_ff.bx_coord; mul_b = widen_coord(beat_ff.cy_coord); end
         STEP_BYCX: begin mul_a = beat_ff.by_coord; mul_b = widen_coord(beat_ff.cx_coord); end
         STEP_AXKX: begin mul_a = beat_ff.ax_coord; mul_b = kx_ff; end
         STEP_AYKY: begin mul_a = beat_ff.ay_coord; mul_b = ky_ff; end
         STEP_AZKZ: begin mul_a = beat_ff.az_coord; mul_b = kz_ff; end
         default:   begin mul_a = '0; mul_b = '0; end
      endcase
   end

   msva_mul u_mul (
      .clock      (clock),
      .a_op       (mul_a),
      .b_op       (mul_b),
      .product_ff (product)
   );

   // coordinate products always fit the cross term width
   assign prod_k = product[K_WIDTH-1:0];
   assign prod_t = {{(TRI_WIDTH-PROD_WIDTH){product[PROD_WIDTH-1]}}, product};

   // saturating add of the finished triple product
   always_comb begin
      sum_wide = {sum_ff[SUM_WIDTH-1], sum_ff}
               + {{(SUM_WIDTH+1-TRI_WIDTH){tri_ff[TRI_WIDTH-1]}}, tri_ff};
      clip     = (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]);
      if (clip) begin
         sum_next = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_next = sum_wide[SUM_WIDTH-1:0];
      end
      // the most negative sum negates to 2^63, exact in unsigned
      magnitude = sum_next[SUM_WIDTH-1] ? (~sum_next + 1'b1) : sum_next;
   end

   assign div_start = (state_ff == ST_ACCUM) && beat_ff.last_triangle;

   msva_div6 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (magnitude),
      .done_ff  (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      beat_in      = beat_ff;
      part_in      = part_ff;
      kx_in        = kx_ff;
      ky_in        = ky_ff;
      kz_in        = kz_ff;
      tri_in       = tri_ff;
      sum_in       = sum_ff;
      seen_in      = seen_ff;
      sat_pend_in  = sat_pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (take_req) begin
               beat_in  = req_chan.payload;
               step_in  = STEP_BYCZ;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            // product of the previous step lands this cycle
            if (step_ff != STEP_BYCZ) begin
               case (prev_step)
                  STEP_BYCZ, STEP_BZCX, STEP_BXCY: part_in = prod_k;
                  STEP_BZCY: kx_in  = part_ff - prod_k;
                  STEP_BXCZ: ky_in  = part_ff - prod_k;
                  STEP_BYCX: kz_in  = part_ff - prod_k;
                  STEP_AXKX: tri_in = prod_t;
                  STEP_AYKY, STEP_AZKZ: tri_in = tri_ff + prod_t;
                  default: ;
               endcase
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_DRAIN) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (beat_ff.last_triangle) begin
               sat_pend_in = seen_ff || clip;
               sum_in      = '0;
               seen_in     = 1'b0;
               state_in    = ST_DIVIDE;
            end else begin
               sum_in   = sum_next;
               seen_in  = seen_ff || clip;
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in          = 1'b1;
               rsp_beat_in.volume    = div_quotient;
               rsp_beat_in.saturated = sat_pend_ff;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         sum_ff       <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      beat_ff     <= beat_in;
      part_ff     <= part_in;
      kx_ff       <= kx_in;
      ky_ff       <= ky_in;
      kz_ff       <= kz_in;
      tri_ff      <= tri_in;
      sat_pend_ff <= sat_pend_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_beat_ff;

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside emit");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside divide state");

   a_mesh_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM && beat_ff.last_triangle) |=> (sum_ff == '0 && !seen_ff))
      else $error("sum not cleared after last triangle");

   a_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      (seen_ff && !(state_ff == ST_ACCUM && beat_ff.last_triangle)) |=> seen_ff)
      else $error("saturation flag dropped mid mesh");
endmodule

[dv/tb.sv]
module tb;
   import msva_pkg::*;

   localparam int     CoordMin = -32768;
   localparam int     CoordMax = 32767;
   localparam longint SumTop   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam longint SumFloor = 64'h8000_0000_0000_0000;
   localparam int     HoldOff  = 2000;

   class mesh_volume_tracker;
      longint       mesh_sum;
      bit           clip_seen;
      rsp_beat_type pending_volumes[$];
      int           failures;

      // a.(b x c), exact; 24 fraction bits
      function longint triple_product(req_beat_type t);
         longint ax, ay, az, bx, by, bz, cx, cy, cz;
         longint kx, ky, kz;
         ax = $signed(t.ax_coord);
         ay = $signed(t.ay_coord);
         az = $signed(t.az_coord);
         bx = $signed(t.bx_coord);
         by = $signed(t.by_coord);
         bz = $signed(t.bz_coord);
         cx = $signed(t.cx_coord);
         cy = $signed(t.cy_coord);
         cz = $signed(t.cz_coord);
         kx = by * cz - bz * cy;
         ky = bz * cx - bx * cz;
         kz = bx * cy - by * cx;
         return ax * kx + ay * ky + az * kz;
      endfunction

      function void add_triangle(req_beat_type t);
         longint       product;
         bit [63:0]    mag;
         rsp_beat_type want;
         product = triple_product(t);
         if (product > 0 && mesh_sum > SumTop - product) begin
            mesh_sum  = SumTop;
            clip_seen = 1'b1;
         end else if (product < 0 && mesh_sum < SumFloor - product) begin
            mesh_sum  = SumFloor;
            clip_seen = 1'b1;
         end else begin
            mesh_sum += product;
         end
         if (t.last_triangle) begin
            mag = mesh_sum;
            // unsigned negate: the floor value comes out as exactly 2^63
            if (mesh_sum < 0) begin
               mag = -mag;
            end
            want.volume    = VOLUME_WIDTH'(mag / VolDivisor);
            want.saturated = clip_seen;
            pending_volumes.push_back(want);
            mesh_sum  = 0;
            clip_seen = 1'b0;
         end
      endfunction

      function void check_volume(rsp_beat_type got);
         rsp_beat_type want;
         if (pending_volumes.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("unexpected volume beat: volume %0d saturated %0b",
                        got.volume, got.saturated);
            end
         end else begin
            want = pending_volumes.pop_front();
            if (got.volume !== want.volume || got.saturated !== want.saturated) begin
               failures++;
               if (failures <= 10) begin
                  $display("volume mismatch: expected %0d/%0b, got %0d/%0b",
                           want.volume, want.saturated, got.volume, got.saturated);
               end
            end
         end
      endfunction

      function int pending();
         return pending_volumes.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct;
   int   rsp_idle_pct;
   logic rsp_hold;
   event rsp_stall_kick;

   mesh_volume_tracker volumes = new;

   msva_req_if req_if ();
   msva_rsp_if rsp_if ();

   mesh_signed_volume_accumulator_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            volumes.add_triangle(req_if.payload);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            volumes.check_volume(rsp_if.payload);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_hold) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // long receiver stall so finished volumes back up into the input
   initial begin
      rsp_hold = 1'b0;
      forever begin
         @(rsp_stall_kick);
         rsp_hold <= 1'b1;
         repeat (HoldOff) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   initial begin
      #(64'd100_000_000);
      $display("[mesh_signed_volume_accumulator_core] ERROR");
      $finish;
   end

   function automatic req_beat_type make_triangle(input int ax, ay, az, bx, by, bz,
                                                  cx, cy, cz, input bit last);
      req_beat_type t;
      t.ax_coord      = 16'(ax);
      t.ay_coord      = 16'(ay);
      t.az_coord      = 16'(az);
      t.bx_coord      = 16'(bx);
      t.by_coord      = 16'(by);
      t.bz_coord      = 16'(bz);
      t.cx_coord      = 16'(cx);
      t.cy_coord      = 16'(cy);
      t.cz_coord      = 16'(cz);
      t.last_triangle = last;
      return t;
   endfunction

   function automatic int random_coord();
      int pick;
      pick = $urandom_range(3);
      if (pick == 0) begin
         return int'($urandom_range(4095)) - 2048;
      end
      if (pick == 1) begin
         case ($urandom_range(4))
            0: return CoordMin;
            1: return CoordMax;
            2: return -1;
            3: return 1;
            default: return 0;
         endcase
      end
      return int'($urandom_range(65535)) - 32768;
   endfunction

   function automatic req_beat_type random_triangle(input bit last);
      return make_triangle(random_coord(), random_coord(), random_coord(),
                           random_coord(), random_coord(), random_coord(),
                           random_coord(), random_coord(), random_coord(), last);
   endfunction

   // valid stays up across back-to-back beats; lowered only for a gap
   task automatic send_triangle(input req_beat_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.payload <= t;
      req_if.valid   <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_random_meshes(input int count);
      int sent;
      int mesh_len;
      sent = 0;
      while (sent < count) begin
         mesh_len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
         for (int i = 0; i < mesh_len; i++) begin
            send_triangle(random_triangle(i == mesh_len - 1));
         end
         sent += mesh_len;
      end
   endtask

   task automatic wait_for_volumes();
      req_if.valid <= 1'b0;
      while (volumes.pending() != 0) @(posedge clock);
   endtask

   initial begin
      req_beat_type pos_full;
      req_beat_type neg_full;
      int           o;
      // rows (p,p,p), (p,q,p), (p,p,q) give det = p*(p-q)^2, close to -2^47
      neg_full = make_triangle(CoordMin, CoordMin, CoordMin, CoordMin, CoordMax, CoordMin,
                               CoordMin, CoordMin, CoordMax, 1'b0);
      pos_full = make_triangle(CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMax,
                               CoordMin, CoordMax, CoordMin, 1'b0);
      o = 256;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      send_idle_pct  = 38;
      rsp_idle_pct   = 87;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
      send_triangle(make_triangle(1, 0, 0, 0, 1, 0, 0, 0, 7, 1'b1));
      send_triangle(make_triangle(1, 0, 0, 0, 0, 7, 0, 1, 0, 1'b1));
      send_triangle(make_triangle(1, 0, 0, 0, 1, 0, 0, 0, 5, 1'b1));
      send_triangle(make_triangle(CoordMin, CoordMin, CoordMin, CoordMin, CoordMin,
                                  CoordMin, CoordMin, CoordMin, CoordMin, 1'b1));
      send_triangle(make_triangle(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax,
                                  CoordMax, CoordMax, CoordMax, CoordMax, 1'b1));
      send_triangle(make_triangle(CoordMin, CoordMax, -1, 1, 0, CoordMin,
                                  CoordMax, -1, CoordMin, 1'b1));
      send_triangle(pos_full);
      send_triangle(neg_full);
      send_triangle(make_triangle(CoordMax, -2, 3, CoordMin, 5, -7, 11, CoordMax, -13, 1'b1));
      // unit tetrahedron at the origin, faces wound outward: volume 1/6
      send_triangle(make_triangle(0, 0, 0, 0, 0, o, 0, o, 0, 1'b0));
      send_triangle(make_triangle(0, 0, 0, o, 0, 0, 0, 0, o, 1'b0));
      send_triangle(make_triangle(0, 0, 0, 0, o, 0, o, 0, 0, 1'b0));
      send_triangle(make_triangle(o, 0, 0, 0, o, 0, 0, 0, o, 1'b1));
      pos_full.last_triangle = 1'b1;
      neg_full.last_triangle = 1'b1;
      send_triangle(pos_full);
      send_triangle(neg_full);
      pos_full.last_triangle = 1'b0;
      neg_full.last_triangle = 1'b0;

      send_random_meshes(650);
      wait_for_volumes();
      send_idle_pct = 87;
      rsp_idle_pct <= 38;
      send_random_meshes(650);
      wait_for_volumes();
      send_idle_pct = 0;
      rsp_idle_pct <= 0;
      send_random_meshes(650);

      -> rsp_stall_kick;
      repeat (8) begin
         send_triangle(random_triangle(1'b0));
         send_triangle(random_triangle(1'b1));
      end
      wait_for_volumes();

      repeat (200) @(posedge clock);
      if (volumes.failures == 0) begin
         $display("[mesh_signed_volume_accumulator_core] OK");
      end else begin
         $display("[mesh_signed_volume_accumulator_core] ERROR");
      end
      $finish;
   end

endmodule
